### hdl/cdm_pkg.sv
// package for the chorus delay modulator: default sizes, register codes,
// reset values and register limits, and the register bundle type
// no dependencies
package cdm_pkg;

	// default sizes, handed to the top level parameters
	localparam int DEF_DELAY_STORE_DEPTH  = 4096;
	localparam int DEF_MAX_DELAY          = 2048;
	localparam int DEF_SINE_TABLE_ENTRIES = 1024;
	localparam int DEF_SAMPLE_BITS        = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	// register field widths
	localparam int DELAY_REG_W = 19;
	localparam int STEP_W      = 16;
	localparam int MIX_W       = 16;
	localparam int FB_W        = 15;

	// register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_DELAY     = 3'd0,
		REG_DEPTH_DELAY    = 3'd1,
		REG_PHASE_STEP     = 3'd2,
		REG_MIX_LEVEL      = 3'd3,
		REG_FEEDBACK_LEVEL = 3'd4
	} cfg_reg_t;

	// values after reset
	localparam logic [DELAY_REG_W-1:0] RST_BASE_DELAY     = 19'd245760;
	localparam logic [DELAY_REG_W-1:0] RST_DEPTH_DELAY    = 19'd61440;
	localparam logic [STEP_W-1:0]      RST_PHASE_STEP     = 16'd280;
	localparam logic [MIX_W-1:0]       RST_MIX_LEVEL      = 16'd16384;
	localparam logic [FB_W-1:0]        RST_FEEDBACK_LEVEL = 15'd6554;

	// upper limits, larger writes saturate
	localparam logic [DELAY_REG_W-1:0] DELAY_LIMIT = 19'd524032;
	localparam logic [MIX_W-1:0]       MIX_LIMIT   = 16'd32768;
	localparam logic [FB_W-1:0]        FB_LIMIT    = 15'd31130;

	// register bundle shared by the top level and the lfo
	typedef struct packed {
		logic [DELAY_REG_W-1:0] base_delay;
		logic [DELAY_REG_W-1:0] depth_delay;
		logic [STEP_W-1:0]      phase_step;
		logic [MIX_W-1:0]       mix_level;
		logic [FB_W-1:0]        feedback_level;
	} cdm_cfg_t;

endpackage

### hdl/cdm_in_if.sv
// input sample channel: valid/ready handshake with sample and block-end mark
// depends on cdm_pkg
interface cdm_in_if import cdm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

### hdl/cdm_out_if.sv
// output sample channel: valid/ready handshake with sample and block-end mark
// depends on cdm_pkg
interface cdm_out_if import cdm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

### hdl/cdm_cfg_if.sv
// configuration write channel: valid/ready handshake with register index and data
// depends on cdm_pkg
interface cdm_cfg_if import cdm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/cdm_lfo.sv
// lfo for the chorus: phase accumulator, sine table, depth scaling and delay clamp
// depends on cdm_pkg
module cdm_lfo import cdm_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES,
	parameter int MAX_DELAY          = DEF_MAX_DELAY,
	localparam int DW                = $clog2(MAX_DELAY) + 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  cdm_cfg_t       cfg,
	output logic [DW-1:0]  delay,
	output logic           done
);

	localparam int TW  = $clog2(SINE_TABLE_ENTRIES);
	localparam int PW  = 24 + TW + 1;
	localparam int PRW = 36;
	localparam int DSW = 26;
	localparam logic [PW-1:0]         ENTRIES_C = PW'(SINE_TABLE_ENTRIES);
	localparam logic signed [PRW-1:0] HALF15    = PRW'(16384);
	localparam logic signed [DSW-1:0] DLO       = DSW'(256);
	localparam logic signed [DSW-1:0] DHI       = DSW'((MAX_DELAY - 1) * 256);

	// table entry: quarter-wave polynomial sine at the entry's phase
	function automatic logic signed [15:0] sine_entry(input int unsigned k);
		logic [63:0] q;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] inner;
		logic [63:0] inner2;
		logic [63:0] s;
		logic [1:0]  quad;
		q = (64'(k) << 24) / SINE_TABLE_ENTRIES;
		quad = q[23:22];
		t = 64'(q[21:6]);
		if (quad[0]) t = 64'd65536 - t;
		t2 = (t * t) >> 16;
		inner = 64'd42334 - ((64'd4926 * t2) >> 16);
		inner2 = 64'd102944 - ((t2 * inner) >> 16);
		s = ((t * inner2) >> 16) >> 1;
		if (s > 64'd32767) s = 64'd32767;
		sine_entry = quad[1] ? -$signed(16'(s)) : $signed(16'(s));
	endfunction

	logic signed [15:0]    sine_rom [SINE_TABLE_ENTRIES];
	logic [23:0]           phase_q;
	logic [4:0]            vld_q;
	logic [TW-1:0]         idx_s1;
	logic signed [15:0]    sine_s2;
	logic signed [PRW-1:0] prod_s3;
	logic [DW-1:0]         delay_s4;
	logic [PW-1:0]         idx_full;
	logic signed [PRW-1:0] rterm;
	logic signed [DSW-1:0] dsum;

	// constant sine table
	for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	// phase accumulator and transfer tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			vld_q   <= '0;
		end else begin
			if (adv) phase_q <= phase_q + 24'(cfg.phase_step);
			vld_q <= {vld_q[3:0], adv};
		end
	end

	// table index from phase
	assign idx_full = PW'(phase_q) * ENTRIES_C;

	// delay around the centre, rounded, then clamped to the usable span
	assign rterm = (prod_s3 + HALF15) >>> 15;
	assign dsum  = DSW'($signed({1'b0, cfg.base_delay})) + DSW'(rterm);

	// pipeline: index, table read, depth product, clamp
	always_ff @(posedge clk) begin
		idx_s1  <= idx_full[24 +: TW];
		sine_s2 <= sine_rom[idx_s1];
		prod_s3 <= PRW'(sine_s2) * PRW'($signed({1'b0, cfg.depth_delay}));
		if (dsum < DLO)
			delay_s4 <= DW'(DLO);
		else if (dsum > DHI)
			delay_s4 <= DW'(DHI);
		else
			delay_s4 <= DW'(dsum);
	end

	assign delay = delay_s4;
	assign done  = vld_q[4];

endmodule

### hdl/chorus_delay_modulator_core.sv
// Chorus delay modulator. Each accepted sample passes in order through the lfo
// pipeline (phase step, table index, table read, depth product, clamp), the
// modulo and read address states, two reads of the single read port of the
// delay store, interpolation and blending, and the write-back, which waits
// while the output register still holds an untaken sample; it then returns to
// the idle state that takes the next sample. A finished sample waits in the
// output register while the next one is accepted. After reset the delay store
// is cleared one entry per cycle, during which no sample is accepted;
// configuration writes are taken always.
// Depends on cdm_pkg, cdm_in_if, cdm_out_if, cdm_cfg_if and cdm_lfo.
module chorus_delay_modulator_core import cdm_pkg::*; #(
	parameter int DELAY_STORE_DEPTH  = DEF_DELAY_STORE_DEPTH,
	parameter int MAX_DELAY          = DEF_MAX_DELAY,
	parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES,
	parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cdm_cfg_if.sink   cfg,
	cdm_in_if.sink    din,
	cdm_out_if.source dout
);

	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = $clog2(DELAY_STORE_DEPTH);
	localparam int DW  = $clog2(MAX_DELAY) + 8;
	localparam int IW  = DW - 8;
	localparam int MW  = ((IW > AW) ? IW : AW) + 1;
	localparam int IPW = SB + 10;
	localparam int WW  = SB + 18;
	localparam int FW  = SB + 16;
	localparam logic [AW:0]          DEPTH_C = (AW + 1)'(DELAY_STORE_DEPTH);
	localparam logic [AW-1:0]        LAST_IX = AW'(DELAY_STORE_DEPTH - 1);
	localparam logic [31:0]          RECIP   = 32'((64'd1 << 32) / DELAY_STORE_DEPTH + 1);
	localparam logic signed [IPW-1:0] HALF8  = IPW'(128);
	localparam logic signed [WW-1:0]  HALF15 = WW'(16384);
	localparam logic signed [FW-1:0]  HALF15F = FW'(16384);
	localparam logic signed [WW-1:0]  SMAX   = WW'((64'sd1 <<< (SB - 1)) - 1);
	localparam logic signed [WW-1:0]  SMIN   = -SMAX - WW'(1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LFO,
		ST_MOD,
		ST_REM,
		ST_ADDR,
		ST_RD0,
		ST_RD1,
		ST_INTP,
		ST_MIX,
		ST_WB
	} state_t;

	// saturate to the sample width
	function automatic logic signed [SB-1:0] sat_smp(input logic signed [WW-1:0] v);
		if (v > SMAX)
			sat_smp = SB'(SMAX);
		else if (v < SMIN)
			sat_smp = SB'(SMIN);
		else
			sat_smp = SB'(v);
	endfunction

	state_t                 state_q;
	cdm_cfg_t               cfg_q;
	logic [AW-1:0]          clr_q;
	logic [AW-1:0]          wi_q;
	logic signed [SB-1:0]   x_q;
	logic                   last_q;
	logic [IW-1:0]          quot_q;
	logic [AW-1:0]          rem_q;
	logic [AW-1:0]          i0_q;
	logic [AW-1:0]          i1_q;
	logic [7:0]             frac_q;
	logic signed [SB-1:0]   s0_q;
	logic signed [IPW-1:0]  interp_q;
	logic signed [WW-1:0]   wet_q;
	logic signed [FW-1:0]   fbp_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   y_q;
	logic                   last_out_q;
	logic signed [SB-1:0]   dly_store_q [DELAY_STORE_DEPTH];
	logic signed [SB-1:0]   rd_q;

	logic                   din_xfer;
	logic                   slot_free;
	logic                   lfo_done;
	logic [DW-1:0]          lfo_delay;
	logic [IW-1:0]          di;
	logic [7:0]             df;
	logic [IW+31:0]         quot_full;
	logic [MW-1:0]          rem_full;
	logic [AW+1:0]          tdiff;
	logic [AW+1:0]          tfix;
	logic [AW-1:0]          i0_n;
	logic [8:0]             w0;
	logic signed [IPW-1:0]  dl_full;
	logic signed [SB-1:0]   delayed;
	logic [16:0]            dry_w;
	logic signed [WW-1:0]   ys;
	logic signed [FW-1:0]   rf;
	logic signed [WW-1:0]   wsum;
	logic signed [SB-1:0]   y_sat;
	logic signed [SB-1:0]   w_sat;
	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic signed [SB-1:0]   mem_wd;
	logic [AW-1:0]          mem_ra;

	// handshakes
	assign din_xfer  = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || dout.ready;
	assign cfg.ready = 1'b1;

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = y_q;
	assign dout.last_out   = last_out_q;

	// register writes, saturated to their limits where one is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_delay     <= RST_BASE_DELAY;
			cfg_q.depth_delay    <= RST_DEPTH_DELAY;
			cfg_q.phase_step     <= RST_PHASE_STEP;
			cfg_q.mix_level      <= RST_MIX_LEVEL;
			cfg_q.feedback_level <= RST_FEEDBACK_LEVEL;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_BASE_DELAY: begin
					cfg_q.base_delay <= (cfg.data > DELAY_LIMIT) ? DELAY_LIMIT : cfg.data;
				end
				REG_DEPTH_DELAY: begin
					cfg_q.depth_delay <= (cfg.data > DELAY_LIMIT) ? DELAY_LIMIT : cfg.data;
				end
				REG_PHASE_STEP: begin
					cfg_q.phase_step <= cfg.data[STEP_W-1:0];
				end
				REG_MIX_LEVEL: begin
					cfg_q.mix_level <= (cfg.data[MIX_W-1:0] > MIX_LIMIT) ?
						MIX_LIMIT : cfg.data[MIX_W-1:0];
				end
				REG_FEEDBACK_LEVEL: begin
					cfg_q.feedback_level <= (cfg.data[FB_W-1:0] > FB_LIMIT) ?
						FB_LIMIT : cfg.data[FB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// modulated delay
	cdm_lfo #(
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
		.MAX_DELAY          (MAX_DELAY)
	) u_lfo (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (din_xfer),
		.cfg    (cfg_q),
		.delay  (lfo_delay),
		.done   (lfo_done)
	);

	assign di = lfo_delay[DW-1:8];
	assign df = lfo_delay[7:0];

	// whole samples of delay modulo the store depth, by reciprocal product
	assign quot_full = (IW + 32)'(di) * (IW + 32)'(RECIP);
	assign rem_full  = MW'(di) - MW'(quot_q) * MW'(DELAY_STORE_DEPTH);

	// older read index behind the write index, wrapped into the store
	assign tdiff = (AW + 2)'(wi_q) - (AW + 2)'(rem_q) - (AW + 2)'(df != 8'd0);
	assign tfix  = tdiff[AW+1] ? tdiff + (AW + 2)'(DELAY_STORE_DEPTH) : tdiff;
	assign i0_n  = tfix[AW-1:0];

	// interpolation rounding and blend weights
	assign w0      = 9'd256 - {1'b0, frac_q};
	assign dl_full = (interp_q + HALF8) >>> 8;
	assign delayed = dl_full[SB-1:0];
	assign dry_w   = 17'd32768 - {1'b0, cfg_q.mix_level};

	// output and feedback write, rounded and saturated
	assign ys    = (wet_q + HALF15) >>> 15;
	assign y_sat = sat_smp(ys);
	assign rf    = (fbp_q + HALF15F) >>> 15;
	assign wsum  = WW'(x_q) + WW'(rf);
	assign w_sat = sat_smp(wsum);

	// store port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wi_q;
		mem_wd = w_sat;
		mem_ra = i0_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			ST_RD1: begin
				mem_ra = i1_q;
			end
			ST_WB: begin
				mem_we = slot_free;
			end
			default: begin
			end
		endcase
	end

	// delay store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) dly_store_q[mem_wa] <= mem_wd;
		rd_q <= dly_store_q[mem_ra];
	end

	// output register flag: set by the write-back, cleared by an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WB && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (dout.valid && dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wi_q        <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= (clr_q == LAST_IX) ? '0 : clr_q + AW'(1);
					if (clr_q == LAST_IX) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (din_xfer) begin
						x_q     <= din.sample_in;
						last_q  <= din.last_in;
						state_q <= ST_LFO;
					end
				end
				ST_LFO: begin
					if (lfo_done) state_q <= ST_MOD;
				end
				ST_MOD: begin
					quot_q  <= quot_full[32 +: IW];
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q   <= rem_full[AW-1:0];
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					i0_q    <= i0_n;
					i1_q    <= (i0_n == LAST_IX) ? '0 : i0_n + AW'(1);
					frac_q  <= (df == 8'd0) ? 8'd0 : 8'(9'd256 - {1'b0, df});
					state_q <= ST_RD0;
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					s0_q    <= rd_q;
					state_q <= ST_INTP;
				end
				ST_INTP: begin
					interp_q <= IPW'(s0_q) * IPW'($signed({1'b0, w0}))
						+ IPW'(rd_q) * IPW'($signed({1'b0, frac_q}));
					state_q  <= ST_MIX;
				end
				ST_MIX: begin
					wet_q <= WW'(x_q) * WW'($signed({1'b0, dry_w}))
						+ WW'(delayed) * WW'($signed({1'b0, cfg_q.mix_level}));
					fbp_q <= FW'(delayed) * FW'($signed({1'b0, cfg_q.feedback_level}));
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (slot_free) begin
						y_q         <= y_sat;
						last_out_q  <= last_q;
						wi_q        <= (wi_q == LAST_IX) ? '0 : wi_q + AW'(1);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the lfo delay is ready a fixed time after each input transfer
	a_lfo_latency: assert property (@(posedge clk) disable iff (!arst_n)
		din_xfer |-> ##5 lfo_done)
		else $error("lfo delay not ready five cycles after input transfer");

	// no sample is taken while the store is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !din.ready)
		else $error("input ready during store clear");

	// a new result only appears from the write-back step
	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB))
		else $error("output loaded outside write-back");

	// both read indices lie inside the store
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> (((AW + 1)'(i0_q) < DEPTH_C) && ((AW + 1)'(i1_q) < DEPTH_C)))
		else $error("store read index out of range");

endmodule

### sim/tb_chorus_delay_modulator_core.sv
// testbench for chorus_delay_modulator_core: random and directed samples with a
// bit-true prediction of the lfo, delay store, interpolation and blend
// depends on cdm_pkg, cdm_in_if, cdm_out_if, cdm_cfg_if and the core itself
module tb_chorus_delay_modulator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import cdm_pkg::*;

	localparam int     STORE_DEPTH  = DEF_DELAY_STORE_DEPTH;
	localparam int     SINE_ENTRIES = DEF_SINE_TABLE_ENTRIES;
	localparam int     SAMPLE_W     = DEF_SAMPLE_BITS;
	localparam longint Q15_ONE      = 64'sd1 << 15;
	localparam longint DELAY_FLOOR  = 256;
	localparam longint DELAY_CEIL   = longint'(DEF_MAX_DELAY - 1) * 256;
	localparam longint READ_SPAN    = longint'(STORE_DEPTH) * 256;
	localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
	localparam int     HOLD_OFF_LEN = 300;
	localparam int     REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} out_beat_t;

	// tracks the chorus state and holds the outputs still to come
	class chorus_tracker;
		cdm_cfg_t                   regs;
		logic signed [SAMPLE_W-1:0] echo_mem [STORE_DEPTH];
		int unsigned                wr_ptr;
		logic [23:0]                lfo_acc;
		out_beat_t                  pending_out [$];
		int                         failures;

		function new();
			regs.base_delay     = RST_BASE_DELAY;
			regs.depth_delay    = RST_DEPTH_DELAY;
			regs.phase_step     = RST_PHASE_STEP;
			regs.mix_level      = RST_MIX_LEVEL;
			regs.feedback_level = RST_FEEDBACK_LEVEL;
			foreach (echo_mem[k]) echo_mem[k] = '0;
			wr_ptr   = 0;
			lfo_acc  = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BASE_DELAY:     regs.base_delay     = data;
				REG_DEPTH_DELAY:    regs.depth_delay    = data;
				REG_PHASE_STEP:     regs.phase_step     = data[STEP_W-1:0];
				REG_MIX_LEVEL:      regs.mix_level      = data[MIX_W-1:0];
				REG_FEEDBACK_LEVEL: regs.feedback_level = data[FB_W-1:0];
				default: ;
			endcase
		endfunction

		// scaling shift, half rounds up
		function longint round_shift(longint v, int n);
			return (v + (64'sd1 <<< (n - 1))) >>> n;
		endfunction

		function longint clip_sample(longint v);
			if (v > SAMPLE_MAX) return SAMPLE_MAX;
			if (v < SAMPLE_MIN) return SAMPLE_MIN;
			return v;
		endfunction

		// table sine in Q1.15, quarter-wave polynomial on the table grid
		function longint lfo_sine(logic [23:0] ph);
			longint idx, q, t, t2, inner, inner2, s;
			idx = (longint'(ph) * SINE_ENTRIES) >>> 24;
			q = (idx <<< 24) / SINE_ENTRIES;
			t = (q & 64'h3F_FFFF) >>> 6;
			if (q[22]) t = 65536 - t;
			t2 = (t * t) >>> 16;
			inner = 42334 - ((4926 * t2) >>> 16);
			inner2 = 102944 - ((t2 * inner) >>> 16);
			s = ((t * inner2) >>> 16) >>> 1;
			if (s > 32767) s = 32767;
			return q[23] ? -s : s;
		endfunction

		// one accepted input sample: advance the state, queue its output
		function void take_sample(logic signed [SAMPLE_W-1:0] x_in, logic last);
			longint    x, base, depth, mix, fb, d, r, i0, i1, frac, s0, s1, delayed, y, w;
			out_beat_t beat;
			x = x_in;
			base = regs.base_delay;
			if (base > DELAY_LIMIT) base = DELAY_LIMIT;
			depth = regs.depth_delay;
			if (depth > DELAY_LIMIT) depth = DELAY_LIMIT;
			mix = regs.mix_level;
			if (mix > MIX_LIMIT) mix = MIX_LIMIT;
			fb = regs.feedback_level;
			if (fb > FB_LIMIT) fb = FB_LIMIT;

			// modulated delay, clamped to the usable span
			lfo_acc = lfo_acc + regs.phase_step;
			d = base + round_shift(lfo_sine(lfo_acc) * depth, 15);
			if (d < DELAY_FLOOR) d = DELAY_FLOOR;
			if (d > DELAY_CEIL) d = DELAY_CEIL;

			// read position behind the write pointer, wrapping round the store
			r = (longint'(wr_ptr) * 256 + READ_SPAN * 65536 - d) % READ_SPAN;
			i0 = r >>> 8;
			frac = r & 255;
			i1 = (i0 + 1) % STORE_DEPTH;
			s0 = echo_mem[i0];
			s1 = echo_mem[i1];
			delayed = round_shift(s0 * (256 - frac) + s1 * frac, 8);

			// blend and write-back with feedback
			y = clip_sample(round_shift(x * (Q15_ONE - mix) + delayed * mix, 15));
			w = clip_sample(x + round_shift(delayed * fb, 15));
			echo_mem[wr_ptr] = w[SAMPLE_W-1:0];
			wr_ptr = (wr_ptr + 1) % STORE_DEPTH;

			beat.sample = y[SAMPLE_W-1:0];
			beat.last   = last;
			pending_out.push_back(beat);
		endfunction

		function void check_output(logic signed [SAMPLE_W-1:0] s, logic l);
			out_beat_t beat;
			if (pending_out.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%t: output %0d last %b with none expected", $realtime, s, l);
				return;
			end
			beat = pending_out.pop_front();
			if (beat.sample !== s || beat.last !== l) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%t: sample_out exp %0d got %0d, last_out exp %b got %b",
						$realtime, beat.sample, s, beat.last, l);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cdm_cfg_if cfg_bus ();
	cdm_in_if  din_bus ();
	cdm_out_if dout_bus ();

	chorus_delay_modulator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.din    (din_bus),
		.dout   (dout_bus)
	);

	chorus_tracker tracker = new();

	int unsigned tx_gap_max = 0;
	int unsigned burst_left = 0;
	bit          rx_stalls  = 0;
	int unsigned hold_cycles = 0;

	// clock
	always #6 clk = ~clk;

	// known levels from the start
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.sample_in = '0;
		din_bus.last_in = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
	end

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		bit          rdy_state;
		int unsigned run_left;
		int unsigned n;
		rdy_state = 1'b0;
		run_left = 0;
		dout_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				dout_bus.ready <= 1'b0;
				repeat (n) @(negedge clk);
				hold_cycles = 0;
			end else if (!rx_stalls) begin
				dout_bus.ready <= 1'b1;
			end else if (run_left == 0) begin
				rdy_state = !rdy_state;
				run_left = rdy_state ? $urandom_range(1, 10) : $urandom_range(1, 5);
				dout_bus.ready <= rdy_state;
			end else begin
				run_left--;
				dout_bus.ready <= rdy_state;
			end
		end
	end

	// output transfers
	always @(posedge clk) begin
		if (dout_bus.valid === 1'b1 && dout_bus.ready === 1'b1)
			tracker.check_output(dout_bus.sample_out, dout_bus.last_out);
	end

	// run limit
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// one input transfer, with the burst gaps of the sender
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic l);
		int unsigned gap;
		gap = 0;
		if (tx_gap_max != 0) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, tx_gap_max);
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
		if (gap != 0) begin
			@(negedge clk);
			din_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		din_bus.valid     <= 1'b1;
		din_bus.sample_in <= s;
		din_bus.last_in   <= l;
		do @(posedge clk); while (din_bus.ready !== 1'b1);
		tracker.take_sample(s, l);
	endtask

	task automatic tx_quiet();
		@(negedge clk);
		din_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending_out.size() != 0) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
			1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
			2:       return SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// register value: mostly in the useful range, sometimes at the edges
	function automatic int unsigned pick_field(int unsigned full_max, int unsigned limit,
			int unsigned typical_max);
		case ($urandom_range(0, 19))
			0, 1:    return 0;
			2:       return full_max;
			3:       return limit;
			4, 5:    return $urandom_range(0, full_max);
			default: return $urandom_range(0, typical_max);
		endcase
	endfunction

	// stimulus
	initial begin
		int ph, i, n, k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, sample extremes and both block-end marks
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd32767, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd32767, 1'b0);
		tx_quiet();
		wait_drained();

		// shortest delay, all wet, strongest feedback: store write saturates
		cfg_write(REG_BASE_DELAY, '0);
		cfg_write(REG_DEPTH_DELAY, '0);
		cfg_write(REG_PHASE_STEP, CFG_DATA_W'(16'hFFFF));
		cfg_write(REG_MIX_LEVEL, CFG_DATA_W'(MIX_LIMIT));
		cfg_write(REG_FEEDBACK_LEVEL, CFG_DATA_W'(FB_LIMIT));
		for (i = 0; i < 4; i++) send_sample(16'sd32767, i[0]);
		for (i = 0; i < 3; i++) send_sample(-16'sd32768, 1'b0);
		tx_quiet();
		wait_drained();

		// every limited register above its limit, longest delay, frozen lfo
		cfg_write(REG_BASE_DELAY, '1);
		cfg_write(REG_DEPTH_DELAY, '1);
		cfg_write(REG_PHASE_STEP, '0);
		cfg_write(REG_MIX_LEVEL, CFG_DATA_W'(16'hFFFF));
		cfg_write(REG_FEEDBACK_LEVEL, CFG_DATA_W'(15'h7FFF));
		// unknown indexes must leave the settings alone
		for (k = int'(REG_FEEDBACK_LEVEL) + 1; k < (1 << CFG_IDX_W); k++)
			cfg_write(CFG_IDX_W'(k), '0);
		for (i = 0; i < 5; i++) send_sample(i[0] ? -16'sd32768 : 16'sd32767, i[1]);
		tx_quiet();
		wait_drained();

		// random phases, each with new settings and one of three idling styles in turn
		for (ph = 0; ph < 12; ph++) begin
			cfg_write(REG_BASE_DELAY,
				CFG_DATA_W'(pick_field(19'h7FFFF, DELAY_LIMIT, 40 * 256)));
			cfg_write(REG_DEPTH_DELAY,
				CFG_DATA_W'(pick_field(19'h7FFFF, DELAY_LIMIT, 40 * 256)));
			cfg_write(REG_PHASE_STEP,
				CFG_DATA_W'(pick_field(16'hFFFF, 16'hFFFF, 16'hFFFF)));
			cfg_write(REG_MIX_LEVEL,
				CFG_DATA_W'(pick_field(16'hFFFF, MIX_LIMIT, MIX_LIMIT)));
			cfg_write(REG_FEEDBACK_LEVEL,
				CFG_DATA_W'(pick_field(15'h7FFF, FB_LIMIT, FB_LIMIT)));

			case (ph % 3)
				0: begin
					tx_gap_max = 0;
					rx_stalls = 1'b0;
				end
				1: begin
					tx_gap_max = 4;
					rx_stalls = 1'b1;
				end
				default: begin
					tx_gap_max = 20;
					rx_stalls = 1'b1;
				end
			endcase
			burst_left = 0;

			// long receiver hold-off so the core fills and stalls its input
			if (ph == 4 || ph == 9)
				hold_cycles = HOLD_OFF_LEN;

			n = $urandom_range(60, 90);
			for (i = 0; i < n; i++) begin
				send_sample(random_sample(), $urandom_range(0, 7) == 0);
				// sender pause until everything outstanding has come back
				if (ph % 4 == 3 && i == n / 2) begin
					tx_quiet();
					wait_drained();
				end
			end
			tx_quiet();
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_out.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
